FILE: design/sit_pkg.sv
// Shared types for the segment intersection test pipeline.
`timescale 1ns / 1ps

package sit_pkg;

  typedef struct packed {
    logic load_mul;
    logic load_sum;
  } sit_adv_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sit_sign_t;

endpackage

FILE: design/segment_intersection_test_unit.sv
// Top level of the pipelined closed-segment intersection test.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  a_x a_y b_x b_y c_x c_y d_x d_y
// out       output     out_valid/out_stall  crosses
//
// Every transaction passes four register stages: differences, products,
// signed sums, and the final decision register, in that order.
// One transaction is accepted per cycle while the output is taken.
// Reset clears the stage valid bits; the data registers hold no reset.
// A stall holds only the stages that are full, so bubbles are squeezed out.
`timescale 1ns / 1ps

module segment_intersection_test_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] c_x,
  input  logic signed [31:0] c_y,
  input  logic signed [31:0] d_x,
  input  logic signed [31:0] d_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               crosses
);

  localparam int DW = COORD_BITS + 1;

  function automatic logic signed [DW-1:0] ext(input logic [31:0] v);
    ext = {v[COORD_BITS-1], v[COORD_BITS-1:0]};
  endfunction

  logic valid1;
  logic valid2;
  logic valid3;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  sit_pkg::sit_adv_t adv;

  logic signed [DW-1:0] ab_x, ab_y, cd_x, cd_y, ca_x, ca_y, da_x, da_y;
  logic signed [DW-1:0] ac_x, ac_y, bc_x, bc_y, bd_x, bd_y, db_x, db_y;

  sit_pkg::sit_sign_t s1, s2, s3, s4;
  sit_pkg::sit_sign_t oc1, oc2, oc3, oc4;
  sit_pkg::sit_sign_t od1, od2, od3, od4;

  logic collinear;
  logic on_any;
  logic straddle;
  logic crosses_next;

  assign rdy4 = !out_valid || !out_stall;
  assign rdy3 = !valid3 || rdy4;
  assign rdy2 = !valid2 || rdy3;
  assign rdy1 = !valid1 || rdy2;
  assign in_stall = !rdy1;
  assign adv.load_mul = rdy2;
  assign adv.load_sum = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        valid1 <= in_valid;
      end
      if (rdy2) begin
        valid2 <= valid1;
      end
      if (rdy3) begin
        valid3 <= valid2;
      end
      if (rdy4) begin
        out_valid <= valid3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ab_x <= ext(b_x) - ext(a_x);
      ab_y <= ext(b_y) - ext(a_y);
      cd_x <= ext(d_x) - ext(c_x);
      cd_y <= ext(d_y) - ext(c_y);
      ca_x <= ext(c_x) - ext(a_x);
      ca_y <= ext(c_y) - ext(a_y);
      da_x <= ext(d_x) - ext(a_x);
      da_y <= ext(d_y) - ext(a_y);
      ac_x <= ext(a_x) - ext(c_x);
      ac_y <= ext(a_y) - ext(c_y);
      bc_x <= ext(b_x) - ext(c_x);
      bc_y <= ext(b_y) - ext(c_y);
      bd_x <= ext(b_x) - ext(d_x);
      bd_y <= ext(b_y) - ext(d_y);
      db_x <= ext(d_x) - ext(b_x);
      db_y <= ext(d_y) - ext(b_y);
    end
  end

  // Orientation of C and D against A-B, and of A and B against C-D.
  sit_term #(.DIFF_BITS(DW)) u_s1 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(ab_x), .q(ca_y), .r(ab_y), .s(ca_x), .result(s1));
  sit_term #(.DIFF_BITS(DW)) u_s2 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(ab_x), .q(da_y), .r(ab_y), .s(da_x), .result(s2));
  sit_term #(.DIFF_BITS(DW)) u_s3 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(cd_x), .q(ac_y), .r(cd_y), .s(ac_x), .result(s3));
  sit_term #(.DIFF_BITS(DW)) u_s4 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(cd_x), .q(bc_y), .r(cd_y), .s(bc_x), .result(s4));

  // Endpoint-on-segment tests: C on A-B, D on A-B, A on C-D, B on C-D.
  sit_term #(.DIFF_BITS(DW)) u_oc1 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(ca_x), .q(bc_y), .r(ca_y), .s(bc_x), .result(oc1));
  sit_term #(.DIFF_BITS(DW)) u_od1 (.clk(clk), .adv(adv), .sub(1'b0),
    .p(ca_x), .q(bc_x), .r(ca_y), .s(bc_y), .result(od1));
  sit_term #(.DIFF_BITS(DW)) u_oc2 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(da_x), .q(bd_y), .r(da_y), .s(bd_x), .result(oc2));
  sit_term #(.DIFF_BITS(DW)) u_od2 (.clk(clk), .adv(adv), .sub(1'b0),
    .p(da_x), .q(bd_x), .r(da_y), .s(bd_y), .result(od2));
  sit_term #(.DIFF_BITS(DW)) u_oc3 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(ac_x), .q(da_y), .r(ac_y), .s(da_x), .result(oc3));
  sit_term #(.DIFF_BITS(DW)) u_od3 (.clk(clk), .adv(adv), .sub(1'b0),
    .p(ac_x), .q(da_x), .r(ac_y), .s(da_y), .result(od3));
  sit_term #(.DIFF_BITS(DW)) u_oc4 (.clk(clk), .adv(adv), .sub(1'b1),
    .p(bc_x), .q(db_y), .r(bc_y), .s(db_x), .result(oc4));
  sit_term #(.DIFF_BITS(DW)) u_od4 (.clk(clk), .adv(adv), .sub(1'b0),
    .p(bc_x), .q(db_x), .r(bc_y), .s(db_y), .result(od4));

  always_comb begin
    collinear = s1.zero && s2.zero && s3.zero && s4.zero;
    on_any = (oc1.zero && !od1.neg) || (oc2.zero && !od2.neg) ||
             (oc3.zero && !od3.neg) || (oc4.zero && !od4.neg);
    straddle = (s1.zero || s2.zero || (s1.neg != s2.neg)) &&
               (s3.zero || s4.zero || (s3.neg != s4.neg));
    if (collinear) begin
      crosses_next = on_any;
    end else begin
      crosses_next = straddle;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      crosses <= crosses_next;
    end
  end

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (valid1 && valid2 && valid3 && out_valid))
    else $error("Input stalled while a pipeline stage was empty.");

  a_hold_stage3: assert property (@(posedge clk) disable iff (rst)
    (valid3 && out_valid && out_stall) |=> valid3)
    else $error("A transaction in the sum stage was lost during a stall.");

  a_fill_output: assert property (@(posedge clk) disable iff (rst)
    (valid3 && !out_valid) |=> out_valid)
    else $error("A finished transaction did not move into the empty output register.");

  a_drain_stage1: assert property (@(posedge clk) disable iff (rst)
    (valid1 && !valid2) |=> valid2)
    else $error("A transaction did not advance into the empty product stage.");
`endif

endmodule

FILE: design/sit_term.sv
// Two-stage signed product-pair unit that reports the sign of p*q + r*s or p*q - r*s.
`timescale 1ns / 1ps

module sit_term #(
  parameter int DIFF_BITS = 33
) (
  input  logic                        clk,
  input  sit_pkg::sit_adv_t           adv,
  input  logic                        sub,
  input  logic signed [DIFF_BITS-1:0] p,
  input  logic signed [DIFF_BITS-1:0] q,
  input  logic signed [DIFF_BITS-1:0] r,
  input  logic signed [DIFF_BITS-1:0] s,
  output sit_pkg::sit_sign_t          result
);

  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  logic signed [PROD_BITS-1:0] prod_a;
  logic signed [PROD_BITS-1:0] prod_b;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [SUM_BITS-1:0]  ext_a;
  logic signed [SUM_BITS-1:0]  ext_b;
  sit_pkg::sit_sign_t          result_next;

  assign ext_a = {prod_a[PROD_BITS-1], prod_a};
  assign ext_b = {prod_b[PROD_BITS-1], prod_b};

  always_comb begin
    if (sub) begin
      sum = ext_a - ext_b;
    end else begin
      sum = ext_a + ext_b;
    end
    result_next.neg  = sum[SUM_BITS-1];
    result_next.zero = (sum == '0);
  end

  always_ff @(posedge clk) begin
    if (adv.load_mul) begin
      prod_a <= PROD_BITS'(p) * PROD_BITS'(q);
      prod_b <= PROD_BITS'(r) * PROD_BITS'(s);
    end
    if (adv.load_sum) begin
      result <= result_next;
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the segment intersection test unit.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_BITS = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS = 40;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [127:0] wide_t;

  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7fff_ffff;

  logic   clk = 1'b0;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   crosses;

  bit     pending_crosses[$];
  bit     idle_on = 1'b1;
  int     stall_left = 0;
  int     calm_left = 0;
  int     cycles = 0;
  int     errors = 0;
  int     pairs_sent = 0;
  int     hits_seen = 0;
  int     misses_seen = 0;

  segment_intersection_test_unit #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
    .c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .crosses(crosses)
  );

  always #10 clk = ~clk;

  function automatic longint coord_value(coord_t raw);
    longint v;
    v = longint'(raw);
    v = (v << (64 - COORD_BITS)) >>> (64 - COORD_BITS);
    return v;
  endfunction

  function automatic int sign_of(wide_t v);
    if (v < 0) return -1;
    return (v == 0) ? 0 : 1;
  endfunction

  function automatic int orientation(longint ux, longint uy, longint vx, longint vy);
    return sign_of(wide_t'(ux) * wide_t'(vy) - wide_t'(uy) * wide_t'(vx));
  endfunction

  function automatic bit lies_on(longint px, longint py, longint qx, longint qy,
                                 longint ox, longint oy);
    longint ux, uy, vx, vy;
    ux = ox - px;
    uy = oy - py;
    vx = qx - ox;
    vy = qy - oy;
    if (orientation(ux, uy, vx, vy) != 0) return 1'b0;
    return sign_of(wide_t'(ux) * wide_t'(vx) + wide_t'(uy) * wide_t'(vy)) >= 0;
  endfunction

  function automatic bit straddles(int s1, int s2);
    return s1 == 0 || s2 == 0 || s1 != s2;
  endfunction

  function automatic bit segments_cross(coord_t rax, coord_t ray, coord_t rbx, coord_t rby,
                                        coord_t rcx, coord_t rcy, coord_t rdx, coord_t rdy);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    int s1, s2, s3, s4;
    ax = coord_value(rax);
    ay = coord_value(ray);
    bx = coord_value(rbx);
    by = coord_value(rby);
    cx = coord_value(rcx);
    cy = coord_value(rcy);
    dx = coord_value(rdx);
    dy = coord_value(rdy);
    s1 = orientation(bx - ax, by - ay, cx - ax, cy - ay);
    s2 = orientation(bx - ax, by - ay, dx - ax, dy - ay);
    s3 = orientation(dx - cx, dy - cy, ax - cx, ay - cy);
    s4 = orientation(dx - cx, dy - cy, bx - cx, by - cy);
    if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
      return lies_on(ax, ay, bx, by, cx, cy) || lies_on(ax, ay, bx, by, dx, dy) ||
             lies_on(cx, cy, dx, dy, ax, ay) || lies_on(cx, cy, dx, dy, bx, by);
    end
    return straddles(s1, s2) && straddles(s3, s4);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MIN;
      1: return C_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_near(int span);
    return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_crosses.size());
      $display("segment_intersection_test_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_crosses.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with none expected: expected none, actual crosses=%b",
                     $time, crosses);
        end else begin
          want = pending_crosses.pop_front();
          if (crosses !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: crosses mismatch: expected %b, actual %b", $time, want, crosses);
          end
          if (want) hits_seen++;
          else misses_seen++;
        end
      end
      if (in_valid && !in_stall)
        pending_crosses.push_back(segments_cross(a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y));
    end
  end

  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
    end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 14);
      if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 80);
    end
    out_stall = idle_on && (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic send_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                           coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    a_x = ax;
    a_y = ay;
    b_x = bx;
    b_y = by;
    c_x = cx;
    c_y = cy;
    d_x = dx;
    d_y = dy;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic test_directed_geometry();
    send_pair(0, 0, 10, 10, 0, 10, 10, 0);
    send_pair(0, 0, 10, 0, 0, 1, 10, 1);
    send_pair(0, 0, 10, 0, 5, 0, 5, 5);
    send_pair(0, 0, 5, 5, 5, 5, 9, 0);
    send_pair(0, 0, 10, 0, 5, 0, 15, 0);
    send_pair(0, 0, 4, 0, 5, 0, 9, 0);
    send_pair(0, 0, 5, 0, 5, 0, 9, 0);
    send_pair(0, 0, 10, 10, 2, 2, 3, 3);
    send_pair(3, 3, 3, 3, 0, 0, 6, 6);
    send_pair(3, 4, 3, 4, 0, 0, 6, 6);
    send_pair(7, -2, 7, -2, 7, -2, 7, -2);
    send_pair(7, -2, 7, -2, 8, -2, 8, -2);
    send_pair(0, 0, 1, 1, 3, 0, 2, 1);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_directed_extremes();
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
    send_pair(C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, -1, -1);
    send_pair(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX);
    send_pair(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    send_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX - 1, C_MAX - 1, C_MAX - 1);
    send_pair(C_MIN, C_MIN, -1, -1, 0, 0, C_MAX, C_MAX);
    send_pair(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
    send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_random_wide(int count);
    repeat (count)
      send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_random_grid(int count);
    repeat (count)
      send_pair(rand_near(6), rand_near(6), rand_near(6), rand_near(6),
                rand_near(6), rand_near(6), rand_near(6), rand_near(6));
  endtask

  task automatic test_random_collinear(int count);
    coord_t px, py, ux, uy;
    coord_t t[4];
    repeat (count) begin
      px = rand_near(1 << 30);
      py = rand_near(1 << 30);
      ux = rand_near(100);
      uy = rand_near(100);
      foreach (t[i]) t[i] = rand_near(8);
      send_pair(px + t[0] * ux, py + t[0] * uy, px + t[1] * ux, py + t[1] * uy,
                px + t[2] * ux, py + t[2] * uy, px + t[3] * ux, py + t[3] * uy);
    end
  endtask

  task automatic test_random_touching(int count);
    coord_t p[4][2];
    int src, dst;
    repeat (count) begin
      foreach (p[i]) begin
        p[i][0] = ($urandom_range(0, 1) == 0) ? rand_coord() : rand_near(20);
        p[i][1] = ($urandom_range(0, 1) == 0) ? rand_coord() : rand_near(20);
      end
      src = $urandom_range(0, 3);
      dst = $urandom_range(0, 3);
      p[dst] = p[src];
      if ($urandom_range(0, 2) == 0) p[$urandom_range(0, 3)] = p[$urandom_range(0, 3)];
      send_pair(p[0][0], p[0][1], p[1][0], p[1][1], p[2][0], p[2][1], p[3][0], p[3][1]);
    end
  endtask

  task automatic test_streaming(int count);
    idle_on = 1'b0;
    repeat (count) begin
      case ($urandom_range(0, 2))
        0: test_random_wide(1);
        1: test_random_grid(1);
        default: test_random_collinear(1);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    a_x = 0;
    a_y = 0;
    b_x = 0;
    b_y = 0;
    c_x = 0;
    c_y = 0;
    d_x = 0;
    d_y = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_geometry();
    test_directed_extremes();
    test_random_wide(140);
    test_random_grid(130);
    test_random_collinear(100);
    test_random_touching(70);
    test_streaming(60);

    in_valid = 1'b0;
    while (pending_crosses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d segment pairs (directed, wide random, small grid, collinear,",
             pairs_sent);
    $display("shared endpoints, back to back); %0d crossing and %0d apart.",
             hits_seen, misses_seen);
    if (errors == 0 && pending_crosses.size() == 0) begin
      $display("segment_intersection_test_unit: match");
    end else begin
      $display("segment_intersection_test_unit: mismatch");
    end
    $finish;
  end

endmodule
